FILE: design/spq_pkg.sv
// Shared types and constants for the strict priority class queues.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int HANDLE_W     = 16;
    localparam int CLS_W        = 3;
    localparam int OCLS_W       = 2;
    localparam int CAP_W        = 5;
    localparam int NUM_CAP_REGS = 4;
    localparam int CFG_IDX_W    = 3;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LAST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DMASK    = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

    typedef struct packed {
        logic [NUM_CAP_REGS-1:0][CAP_W-1:0] cap;
        logic [NUM_CAP_REGS-1:0]            dmask;
    } t_cfg;

    typedef struct packed {
        logic                func;
        logic                matched;
        logic [CLS_W-1:0]    cls;
        logic [HANDLE_W-1:0] handle;
    } t_cmd;

    typedef enum logic {
        BK_EXEC,
        BK_READ
    } t_bk_state;

endpackage

FILE: design/spq_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface spq_in_if;
    import spq_pkg::*;
    logic                valid;
    logic                ready;
    logic                func;
    logic [CLS_W-1:0]    class_index;
    logic [HANDLE_W-1:0] packet_handle;

    modport source (output valid, func, class_index, packet_handle, input ready);
    modport sink   (input valid, func, class_index, packet_handle, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;
    logic                valid;
    logic                ready;
    logic                accepted;
    logic                out_valid;
    logic [HANDLE_W-1:0] out_packet;
    logic [OCLS_W-1:0]   out_class;

    modport source (output valid, accepted, out_valid, out_packet, out_class, input ready);
    modport sink   (input valid, accepted, out_valid, out_packet, out_class, output ready);
endinterface

FILE: design/spq_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: design/spq_front.sv
// Front end: takes requests, flags class match, buffers them in a two-entry queue.
`timescale 1ns / 1ps

module spq_front import spq_pkg::*; #(
    parameter int NUM_CLASSES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_in_if.sink      i_req,
    output logic        o_cmd_vld,
    output t_cmd        o_cmd,
    input  logic        i_cmd_rdy
);

    t_cmd       r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_cmd       n_cmd;

    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_vld   = (r_cnt != 2'd0);
    assign pop         = o_cmd_vld && i_cmd_rdy;
    assign o_cmd       = r_buf[r_rp];

    always_comb begin
        n_cmd.func    = i_req.func;
        n_cmd.matched = ({1'b0, i_req.class_index} < 4'(NUM_CLASSES));
        n_cmd.cls     = i_req.class_index;
        n_cmd.handle  = i_req.packet_handle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= n_cmd;
        end
    end

endmodule

FILE: design/spq_back.sv
// Back end: per-class queue state, priority selection, store access, response register.
`timescale 1ns / 1ps

module spq_back import spq_pkg::*; #(
    parameter int NUM_CLASSES = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_vld,
    input  t_cmd        i_cmd,
    output logic        o_cmd_rdy,
    input  t_cfg        i_cfg,
    spq_out_if.source   o_rsp
);

    localparam int CB    = $clog2(NUM_CLASSES);
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int KW    = (CW > CAP_W) ? CW : CAP_W;
    localparam int SW    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    t_bk_state r_state;
    t_bk_state n_state;

    logic [PW-1:0] r_head [NUM_CLASSES];
    logic [PW-1:0] r_tail [NUM_CLASSES];
    logic [CW-1:0] r_cnt  [NUM_CLASSES];
    logic [CB-1:0] r_rd_cls;

    logic                r_o_vld;
    logic                r_o_acc;
    logic                r_o_pv;
    logic [HANDLE_W-1:0] r_o_pkt;
    logic [OCLS_W-1:0]   r_o_cls;

    logic                n_o_acc;
    logic                n_o_pv;
    logic [HANDLE_W-1:0] n_o_pkt;
    logic [OCLS_W-1:0]   n_o_cls;

    logic [NUM_CLASSES-1:0] room;
    logic [NUM_CLASSES-1:0] nempty;
    logic [NUM_CLASSES-1:0] dflt_room;

    logic [CB-1:0] enq_cls;
    logic          enq_ok;
    logic [CB-1:0] deq_cls;
    logic          deq_any;
    logic [CB-1:0] dflt_cls;
    logic          dflt_any;

    logic slot_free;
    logic exec;
    logic is_enq;
    logic do_push;
    logic do_pop;
    logic o_load;

    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [SW-1:0] rdata;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        nxt = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // room, occupancy and default eligibility per class
    always_comb begin
        logic [KW-1:0] cap;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            cap = KW'(QUEUE_DEPTH);
            dflt_room[c] = 1'b0;
            if (c < NUM_CAP_REGS) begin
                if (KW'(i_cfg.cap[2'(c)]) < KW'(QUEUE_DEPTH)) begin
                    cap = KW'(i_cfg.cap[2'(c)]);
                end
            end
            room[c]   = KW'(r_cnt[c]) < cap;
            nempty[c] = (r_cnt[c] != '0);
            if (c < NUM_CAP_REGS) begin
                dflt_room[c] = i_cfg.dmask[2'(c)] && room[c];
            end
        end
    end

    // lowest-numbered wins
    always_comb begin
        deq_cls  = '0;
        deq_any  = 1'b0;
        dflt_cls = '0;
        dflt_any = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (nempty[c]) begin
                deq_cls = CB'(c);
                deq_any = 1'b1;
            end
            if (dflt_room[c]) begin
                dflt_cls = CB'(c);
                dflt_any = 1'b1;
            end
        end
    end

    always_comb begin
        if (i_cmd.matched) begin
            enq_cls = i_cmd.cls[CB-1:0];
            enq_ok  = room[i_cmd.cls[CB-1:0]];
        end else begin
            enq_cls = dflt_cls;
            enq_ok  = dflt_any;
        end
    end

    // next state
    always_comb begin
        unique case (r_state)
            BK_EXEC: n_state = do_pop ? BK_READ : BK_EXEC;
            BK_READ: n_state = BK_EXEC;
            default: n_state = BK_EXEC;
        endcase
    end

    // state outputs
    always_comb begin
        slot_free = !r_o_vld || o_rsp.ready;
        exec      = (r_state == BK_EXEC) && i_cmd_vld && slot_free;
        is_enq    = (i_cmd.func == FUNC_ENQ);
        do_push   = exec && is_enq && enq_ok;
        do_pop    = exec && !is_enq && deq_any;
        o_load    = (exec && !do_pop) || (r_state == BK_READ);
        n_o_acc   = (r_state == BK_EXEC) && do_push;
        n_o_pv    = (r_state == BK_READ);
        n_o_pkt   = (r_state == BK_READ) ? HANDLE_W'(rdata) : '0;
        n_o_cls   = (r_state == BK_READ) ? OCLS_W'(r_rd_cls) : '0;
    end

    assign o_cmd_rdy = exec;

    assign waddr = AW'(enq_cls) * AW'(QUEUE_DEPTH) + AW'(r_tail[enq_cls]);
    assign raddr = AW'(deq_cls) * AW'(QUEUE_DEPTH) + AW'(r_head[deq_cls]);

    spq_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (waddr),
        .i_wdata (i_cmd.handle[SW-1:0]),
        .i_re    (do_pop),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_EXEC;
            r_o_vld <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_cnt[c]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (do_push) begin
                r_tail[enq_cls] <= nxt(r_tail[enq_cls]);
                r_cnt[enq_cls]  <= r_cnt[enq_cls] + CW'(1);
            end
            if (do_pop) begin
                r_head[deq_cls] <= nxt(r_head[deq_cls]);
                r_cnt[deq_cls]  <= r_cnt[deq_cls] - CW'(1);
            end
            if (o_load) begin
                r_o_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_rd_cls <= deq_cls;
        end
        if (o_load) begin
            r_o_acc <= n_o_acc;
            r_o_pv  <= n_o_pv;
            r_o_pkt <= n_o_pkt;
            r_o_cls <= n_o_cls;
        end
    end

    assign o_rsp.valid      = r_o_vld;
    assign o_rsp.accepted   = r_o_acc;
    assign o_rsp.out_valid  = r_o_pv;
    assign o_rsp.out_packet = r_o_pkt;
    assign o_rsp.out_class  = r_o_cls;

endmodule

FILE: design/strict_priority_class_queues.sv
// Top level: per-class packet queues with strict priority service.
//
//  channel  dir  handshake        payload
//  i_req    in   valid/ready      func, class_index, packet_handle
//  o_rsp    out  valid/ready      accepted, out_valid, out_packet, out_class
//  i_cfg_*  in   write enable     i_cfg_idx, i_cfg_data
//
// Enqueues and dequeues of an all-empty set complete in the BK_EXEC state; a
// dequeue that pops goes on through BK_READ, for the registered read of the
// packet store. The front queue registers each request before the back end
// sees it and buffers up to two requests while the response register is held.
// Reset clears pointers and counts; the store itself is not cleared.
`timescale 1ns / 1ps

module strict_priority_class_queues import spq_pkg::*; #(
    parameter int NUM_CLASSES = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spq_in_if.sink               i_req,
    spq_out_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CAP_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    logic cmd_vld;
    logic cmd_rdy;
    t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CAP_REGS; i++) begin
                r_cfg.cap[i] <= CAP_RST;
            end
            r_cfg.dmask <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx <= CFG_CAP_LAST) begin
                r_cfg.cap[i_cfg_idx[1:0]] <= i_cfg_data;
            end else if (i_cfg_idx == CFG_DMASK) begin
                r_cfg.dmask <= i_cfg_data[NUM_CAP_REGS-1:0];
            end
        end
    end

    spq_front #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd),
        .i_cmd_rdy (cmd_rdy)
    );

    spq_back #(
        .NUM_CLASSES (NUM_CLASSES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (cmd_vld),
        .i_cmd     (cmd),
        .o_cmd_rdy (cmd_rdy),
        .i_cfg     (r_cfg),
        .o_rsp     (o_rsp)
    );

endmodule
